>>> src/lfupr_pkg.sv
// Shared types and constants for the LFU page replacement block.
// No dependencies; imported by every other file in src.
`default_nettype none

package lfupr_pkg;

  localparam int unsigned PAGE_W       = 8;
  localparam int unsigned CFG_W        = 4;
  localparam int unsigned FRAME_IDX_W  = 3;
  localparam int unsigned FAULT_W      = 16;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [FAULT_W-1:0] FAULT_MAX       = {FAULT_W{1'b1}};
  localparam logic [CFG_W-1:0]   FRAMES_IN_USE_RST = CFG_W'(8);

  localparam int unsigned FRAMES_DEF      = 8;
  localparam int unsigned PAGES_DEF       = 256;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // Back end status seen by the front end.
  typedef struct packed {
    logic clearing;  // count store sweep in progress, take no beat
    logic pop;       // back end takes the queue head this cycle
  } lfupr_status_t;

endpackage

`default_nettype wire

>>> src/lfupr_front.sv
// Front end: accepts page references, maps each to its count store index,
// and holds them in a two-entry queue. Depends on lfupr_pkg.
`default_nettype none

module lfupr_front #(
  parameter int unsigned PAGES = lfupr_pkg::PAGES_DEF,
  parameter int unsigned CW    = $clog2(PAGES)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [lfupr_pkg::PAGE_W-1:0]  page_i,
  output logic                               busy_o,
  input  wire lfupr_pkg::lfupr_status_t      status_i,
  output logic                               q_valid_o,
  output logic [lfupr_pkg::PAGE_W-1:0]       q_page_o,
  output logic [CW-1:0]                      q_cidx_o
);
  import lfupr_pkg::*;

  localparam int unsigned PAGE_VALUES = 1 << PAGE_W;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Page number to count store index (page modulo PAGES), a constant table.
  logic [CW-1:0] cidx_tbl [PAGE_VALUES];

  for (genvar g = 0; g < PAGE_VALUES; g++) begin : g_tbl
    assign cidx_tbl[g] = CW'(g % PAGES);
  end

  logic [PAGE_W-1:0] page_q [QUEUE_DEPTH];
  logic [CW-1:0]     cidx_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              push;

  assign busy_o = (cnt_q == CNT_W'(QUEUE_DEPTH)) || status_i.clearing;
  assign push   = start_i && !busy_o;

  assign q_valid_o = (cnt_q != '0);
  assign q_page_o  = page_q[rd_ptr_q];
  assign q_cidx_o  = cidx_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
    end
    if (status_i.pop) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
    end
    if (push && !status_i.pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!push && status_i.pop) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      page_q[wr_ptr_q] <= page_i;
      cidx_q[wr_ptr_q] <= cidx_tbl[page_i];
    end
  end

endmodule

`default_nettype wire

>>> src/lfupr_back.sv
// Back end: frame table, per-page count store, victim search and result
// registers. Runs a clearing sweep of the count store after reset.
// Depends on lfupr_pkg.
`default_nettype none

module lfupr_back #(
  parameter int unsigned FRAMES      = lfupr_pkg::FRAMES_DEF,
  parameter int unsigned PAGES       = lfupr_pkg::PAGES_DEF,
  parameter int unsigned COUNT_WIDTH = lfupr_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned CW          = $clog2(PAGES)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [lfupr_pkg::CFG_W-1:0]       frames_in_use_i,
  input  wire logic                              q_valid_i,
  input  wire logic [lfupr_pkg::PAGE_W-1:0]      q_page_i,
  input  wire logic [CW-1:0]                     q_cidx_i,
  output lfupr_pkg::lfupr_status_t               status_o,
  output logic                                   result_valid_o,
  output logic                                   hit_o,
  output logic [lfupr_pkg::FRAME_IDX_W-1:0]      frame_index_o,
  output logic                                   evicted_valid_o,
  output logic [lfupr_pkg::PAGE_W-1:0]           evicted_page_o,
  output logic [lfupr_pkg::FAULT_W-1:0]          fault_count_o
);
  import lfupr_pkg::*;

  localparam int unsigned RW     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned NW     = $clog2(FRAMES + 1);
  localparam int unsigned TREE_P = 1 << $clog2(FRAMES);
  localparam int unsigned KW     = 1 + COUNT_WIDTH + 2 * RW;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_READ  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Frame table
  logic [FRAMES-1:0]      valid_q, valid_d;
  logic [RW-1:0]          rank_q [FRAMES];
  logic [RW-1:0]          rank_d [FRAMES];
  logic [PAGE_W-1:0]      fpage_q [FRAMES];
  logic [PAGE_W-1:0]      fpage_d [FRAMES];
  logic [CW-1:0]          fcidx_q [FRAMES];
  logic [CW-1:0]          fcidx_d [FRAMES];
  logic [COUNT_WIDTH-1:0] fcnt_q [FRAMES];
  logic [COUNT_WIDTH-1:0] fcnt_d [FRAMES];

  // Count store
  logic [COUNT_WIDTH-1:0] count_mem [PAGES];
  logic [COUNT_WIDTH-1:0] rd_q;
  logic                   mem_we, mem_re;
  logic [CW-1:0]          mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic [CW-1:0]          clr_q, clr_d;

  // Item held between the read and execute cycles
  logic [PAGE_W-1:0]      cur_page_q;
  logic [CW-1:0]          cur_cidx_q;
  logic                   s_hit_q;
  logic [RW-1:0]          s_hit_slot_q, s_empty_slot_q, s_victim_q, s_filled_q;
  logic                   s_empty_q;

  // Search results on the queue head
  logic [NW-1:0]          n_act;
  logic [FRAMES-1:0]      act;
  logic                   hit_found, empty_found;
  logic [RW-1:0]          hit_slot, empty_slot, victim;
  logic [NW-1:0]          filled;
  logic [KW-1:0]          node [2*TREE_P];

  // Execute results
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic [RW-1:0]          slot;
  logic                   ev_valid;
  logic [PAGE_W-1:0]      ev_page;
  logic [FAULT_W-1:0]     fault_q, fault_d;

  logic                   res_valid_q;
  logic                   res_hit_q, res_ev_q;
  logic [FRAME_IDX_W-1:0] res_idx_q;
  logic [PAGE_W-1:0]      res_evp_q;

  // Clamp frame count to 1..FRAMES.
  always_comb begin
    if (frames_in_use_i == '0) begin
      n_act = NW'(1);
    end else if (32'(frames_in_use_i) > FRAMES) begin
      n_act = NW'(FRAMES);
    end else begin
      n_act = NW'(frames_in_use_i);
    end
  end

  for (genvar f = 0; f < FRAMES; f++) begin : g_act
    assign act[f] = (32'(f) < 32'(n_act));
  end

  // Hit and empty-frame search: lowest matching frame wins.
  always_comb begin
    hit_found   = 1'b0;
    hit_slot    = '0;
    empty_found = 1'b0;
    empty_slot  = '0;
    for (int f = FRAMES - 1; f >= 0; f--) begin
      if (act[f] && valid_q[f] && fpage_q[f] == q_page_i) begin
        hit_found = 1'b1;
        hit_slot  = RW'(f);
      end
      if (act[f] && !valid_q[f]) begin
        empty_found = 1'b1;
        empty_slot  = RW'(f);
      end
    end
  end

  assign filled = NW'($countones(valid_q & act));

  // Victim: minimum of {inactive, count, load rank, frame} over a tree.
  always_comb begin
    node[0] = '0;
    for (int i = 0; i < TREE_P; i++) begin
      if (i < FRAMES) begin
        node[TREE_P + i] = {~act[i], fcnt_q[i], rank_q[i], RW'(i)};
      end else begin
        node[TREE_P + i] = {KW{1'b1}};
      end
    end
    for (int i = TREE_P - 1; i >= 1; i--) begin
      node[i] = (node[2*i] <= node[2*i+1]) ? node[2*i] : node[2*i+1];
    end
  end

  assign victim = node[1][RW-1:0];

  // Sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    mem_re  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + CW'(1);
        if (clr_q == CW'(PAGES - 1)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (q_valid_i) begin
          mem_re  = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_READ;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign status_o.clearing = (state_q == ST_CLEAR);
  assign status_o.pop      = mem_re;

  assign cnt_new = (rd_q == COUNT_MAX) ? rd_q : rd_q + COUNT_WIDTH'(1);

  // Execute: pick the frame, update ranks, pages and count copies.
  always_comb begin
    valid_d  = valid_q;
    rank_d   = rank_q;
    fpage_d  = fpage_q;
    fcidx_d  = fcidx_q;
    fcnt_d   = fcnt_q;
    fault_d  = fault_q;
    ev_valid = 1'b0;
    ev_page  = '0;
    slot     = s_hit_slot_q;
    if (!s_hit_q) begin
      if (s_empty_q) begin
        slot = s_empty_slot_q;
        rank_d[slot] = s_filled_q;
      end else begin
        slot     = s_victim_q;
        ev_valid = 1'b1;
        ev_page  = fpage_q[slot];
        for (int f = 0; f < FRAMES; f++) begin
          if (act[f] && RW'(f) != slot && rank_q[f] > rank_q[slot]) begin
            rank_d[f] = rank_q[f] - RW'(1);
          end
        end
        rank_d[slot] = RW'(n_act - NW'(1));
      end
      fpage_d[slot] = cur_page_q;
      fcidx_d[slot] = cur_cidx_q;
      valid_d[slot] = 1'b1;
      if (fault_q != FAULT_MAX) begin
        fault_d = fault_q + FAULT_W'(1);
      end
    end
    // Keep every resident copy of this count index in step with the store.
    for (int f = 0; f < FRAMES; f++) begin
      if (valid_d[f] && fcidx_d[f] == cur_cidx_q) begin
        fcnt_d[f] = cnt_new;
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_cidx_q;
    mem_wdata = cnt_new;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == ST_EXEC) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      count_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= count_mem[q_cidx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      valid_q     <= '0;
      fault_q     <= '0;
      res_valid_q <= 1'b0;
      for (int f = 0; f < FRAMES; f++) begin
        rank_q[f] <= '0;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= (state_q == ST_EXEC);
      if (state_q == ST_EXEC) begin
        valid_q <= valid_d;
        fault_q <= fault_d;
        rank_q  <= rank_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      cur_page_q     <= q_page_i;
      cur_cidx_q     <= q_cidx_i;
      s_hit_q        <= hit_found;
      s_hit_slot_q   <= hit_slot;
      s_empty_q      <= empty_found;
      s_empty_slot_q <= empty_slot;
      s_victim_q     <= victim;
      s_filled_q     <= RW'(filled);
    end
    if (state_q == ST_EXEC) begin
      fpage_q   <= fpage_d;
      fcidx_q   <= fcidx_d;
      fcnt_q    <= fcnt_d;
      res_hit_q <= s_hit_q;
      res_idx_q <= FRAME_IDX_W'(slot);
      res_ev_q  <= ev_valid;
      res_evp_q <= ev_page;
    end
  end

  assign result_valid_o  = res_valid_q;
  assign hit_o           = res_hit_q;
  assign frame_index_o   = res_idx_q;
  assign evicted_valid_o = res_ev_q;
  assign evicted_page_o  = res_evp_q;
  assign fault_count_o   = fault_q;

endmodule

`default_nettype wire

>>> src/lfu_page_replacement.sv
// Top level of the LFU page replacement block: configuration register,
// front end queue and back end. Depends on lfupr_pkg, lfupr_front, lfupr_back.
`default_nettype none

// LFU page replacement. Each beat on start_i/page_i is one page reference;
// it is taken at a rising edge with start_i high and busy_o low. Every
// reference gives exactly one result, shown for one cycle with
// result_valid_o high; the receiver cannot stall it, so capture it on that
// edge. fault_count_o holds the running fault total between results.
// The back end works on one reference at a time: the per-page count
// memory is read in the read state and written back in the execute state.
// From accept to result, the count is read while the reference sits at the
// queue head, the reference is then executed, and the result is then
// registered onto the ports. A two-entry
// queue sits between the accepting front end and the back end, so a second
// reference is taken while the first is in work. After reset the count
// memory is swept to zero, one entry per cycle (PAGES entries, 256 by
// default); busy_o stays high for the whole sweep. frames_in_use is written
// over the cfg_valid_i/cfg_data_i channel, which is always ready; write it
// only while no reference is in flight. A value of 0 acts as 1 and a value
// above FRAMES acts as FRAMES.

module lfu_page_replacement #(
  parameter int unsigned FRAMES      = lfupr_pkg::FRAMES_DEF,
  parameter int unsigned PAGES       = lfupr_pkg::PAGES_DEF,
  parameter int unsigned COUNT_WIDTH = lfupr_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic [lfupr_pkg::PAGE_W-1:0]      page_i,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [lfupr_pkg::CFG_W-1:0]       cfg_data_i,
  output logic                                   result_valid_o,
  output logic                                   hit_o,
  output logic [lfupr_pkg::FRAME_IDX_W-1:0]      frame_index_o,
  output logic                                   evicted_valid_o,
  output logic [lfupr_pkg::PAGE_W-1:0]           evicted_page_o,
  output logic [lfupr_pkg::FAULT_W-1:0]          fault_count_o
);
  import lfupr_pkg::*;

  localparam int unsigned CW = $clog2(PAGES);

  logic [CFG_W-1:0]  frames_in_use_q;
  lfupr_status_t     status;
  logic              q_valid;
  logic [PAGE_W-1:0] q_page;
  logic [CW-1:0]     q_cidx;

  // Configuration register: take every write beat.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= FRAMES_IN_USE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      frames_in_use_q <= cfg_data_i;
    end
  end

  // Front end: accept and queue references, map page to count index.
  lfupr_front #(
    .PAGES (PAGES),
    .CW    (CW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .page_i    (page_i),
    .busy_o    (busy_o),
    .status_i  (status),
    .q_valid_o (q_valid),
    .q_page_o  (q_page),
    .q_cidx_o  (q_cidx)
  );

  // Back end: lookup, replacement and count update.
  lfupr_back #(
    .FRAMES      (FRAMES),
    .PAGES       (PAGES),
    .COUNT_WIDTH (COUNT_WIDTH),
    .CW          (CW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frames_in_use_i (frames_in_use_q),
    .q_valid_i       (q_valid),
    .q_page_i        (q_page),
    .q_cidx_i        (q_cidx),
    .status_o        (status),
    .result_valid_o  (result_valid_o),
    .hit_o           (hit_o),
    .frame_index_o   (frame_index_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_count_o   (fault_count_o)
  );

endmodule

`default_nettype wire

>>> tb/tb_lfu_page_replacement.sv
// Self-checking testbench for lfu_page_replacement: directed table and random
// phases, checked against an in-bench LFU predictor or hand-worked results.
// Depends on lfupr_pkg and the lfu_page_replacement RTL only.
`default_nettype none

module tb_lfu_page_replacement;
  import lfupr_pkg::*;

  localparam int unsigned FRAMES = FRAMES_DEF;
  localparam int unsigned PAGES  = PAGES_DEF;
  localparam int unsigned CNT_W  = COUNT_WIDTH_DEF;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Cycles without any beat before the run is declared hung. Covers the
  // post-reset sweep of the count store, the longest sender gap and the
  // block latency, with a wide margin.
  localparam int unsigned HANG_LIMIT  = 4000;
  localparam int unsigned RANDOM_REFS = 520;

  // One result beat as the block reports it.
  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame;
    logic                   ev_valid;
    logic [PAGE_W-1:0]      ev_page;
    logic [FAULT_W-1:0]     faults;
  } lfu_result_t;

  typedef enum logic {OP_REF, OP_CFG} plan_op_e;

  // One row of the directed table: a page reference or a frames_in_use
  // write. Rows with typed set carry a result worked out by hand.
  typedef struct packed {
    plan_op_e          op;
    logic [PAGE_W-1:0] arg;
    logic              typed;
    lfu_result_t       want;
  } plan_row_t;

  localparam lfu_result_t NO_WANT = '0;
  localparam int unsigned PLAN_LEN = 29;

  // Opening rows fill all eight frames, then a full set forces an eviction
  // where every candidate but frame 0 ties on count and the oldest load wins.
  // Later rows walk frames_in_use through 0 (acts as 1), 15 and 9 (act as 8),
  // and shrink it so that pages left in inactive frames are missed and then
  // seen again once the frames come back, which also creates rank ties.
  plan_row_t directed_plan [PLAN_LEN] = '{
    '{OP_REF, 8'd0,   1'b1, '{1'b0, 3'd0, 1'b0, 8'd0,   16'd1}},
    '{OP_REF, 8'd255, 1'b1, '{1'b0, 3'd1, 1'b0, 8'd0,   16'd2}},
    '{OP_REF, 8'd0,   1'b1, '{1'b1, 3'd0, 1'b0, 8'd0,   16'd2}},
    '{OP_REF, 8'd128, 1'b1, '{1'b0, 3'd2, 1'b0, 8'd0,   16'd3}},
    '{OP_REF, 8'd1,   1'b0, NO_WANT},
    '{OP_REF, 8'd2,   1'b0, NO_WANT},
    '{OP_REF, 8'd3,   1'b0, NO_WANT},
    '{OP_REF, 8'd4,   1'b0, NO_WANT},
    '{OP_REF, 8'd5,   1'b0, NO_WANT},
    '{OP_REF, 8'd200, 1'b1, '{1'b0, 3'd1, 1'b1, 8'd255, 16'd9}},
    '{OP_CFG, 8'd0,   1'b0, NO_WANT},
    '{OP_REF, 8'd0,   1'b1, '{1'b1, 3'd0, 1'b0, 8'd0,   16'd9}},
    '{OP_REF, 8'd77,  1'b1, '{1'b0, 3'd0, 1'b1, 8'd0,   16'd10}},
    '{OP_CFG, 8'd15,  1'b0, NO_WANT},
    '{OP_REF, 8'd0,   1'b0, NO_WANT},
    '{OP_CFG, 8'd2,   1'b0, NO_WANT},
    '{OP_REF, 8'd5,   1'b0, NO_WANT},
    '{OP_REF, 8'd170, 1'b0, NO_WANT},
    '{OP_CFG, 8'd8,   1'b0, NO_WANT},
    '{OP_REF, 8'd5,   1'b0, NO_WANT},
    '{OP_CFG, 8'd9,   1'b0, NO_WANT},
    '{OP_REF, 8'd254, 1'b0, NO_WANT},
    '{OP_REF, 8'd3,   1'b0, NO_WANT},
    '{OP_CFG, 8'd3,   1'b0, NO_WANT},
    '{OP_REF, 8'd85,  1'b0, NO_WANT},
    '{OP_REF, 8'd170, 1'b0, NO_WANT},
    '{OP_REF, 8'd85,  1'b0, NO_WANT},
    '{OP_REF, 8'd42,  1'b0, NO_WANT},
    '{OP_CFG, 8'd8,   1'b0, NO_WANT}
  };

  logic                   clk_i;
  logic                   rst_ni      = 1'b0;
  logic                   start_i     = 1'b0;
  logic [PAGE_W-1:0]      page_i      = '0;
  logic                   cfg_valid_i = 1'b0;
  logic [CFG_W-1:0]       cfg_data_i  = '0;
  logic                   busy_o;
  logic                   cfg_ready_o;
  logic                   result_valid_o;
  logic                   hit_o;
  logic [FRAME_IDX_W-1:0] frame_index_o;
  logic                   evicted_valid_o;
  logic [PAGE_W-1:0]      evicted_page_o;
  logic [FAULT_W-1:0]     fault_count_o;

  lfu_page_replacement u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .page_i         (page_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .hit_o          (hit_o),
    .frame_index_o  (frame_index_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_page_o (evicted_page_o),
    .fault_count_o  (fault_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state: frame contents, load order, per-page use counts, the
  // running fault total and the frames_in_use register, all at reset values.
  logic [PAGE_W-1:0]  frame_pg   [FRAMES] = '{default: '0};
  bit                 frame_full [FRAMES] = '{default: 1'b0};
  int unsigned        frame_age  [FRAMES] = '{default: 0};
  logic [CNT_W-1:0]   page_hits  [PAGES]  = '{default: '0};
  logic [FAULT_W-1:0] fault_total = '0;
  logic [CFG_W-1:0]   frames_reg  = FRAMES_IN_USE_RST;

  lfu_result_t pending_results [$];
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  bit          quiet_burst = 1'b0;

  function automatic int unsigned active_frames();
    if (frames_reg == 0) return 1;
    if (frames_reg > FRAMES) return FRAMES;
    return frames_reg;
  endfunction

  function automatic void count_use(logic [PAGE_W-1:0] pg);
    if (page_hits[pg % PAGES] != CNT_MAX) page_hits[pg % PAGES]++;
  endfunction

  // Look the page up in the active frames, fill or evict on a miss and
  // return the result beat the block must produce for this reference.
  function automatic lfu_result_t lfu_reference(logic [PAGE_W-1:0] pg);
    int unsigned n;
    int unsigned slot;
    int unsigned filled;
    int unsigned best;
    int unsigned r;
    logic [CNT_W-1:0] best_cnt;
    logic [CNT_W-1:0] c;
    lfu_result_t res;
    n    = active_frames();
    slot = n;
    res  = '0;
    for (int f = 0; f < n; f++) begin
      if (!res.hit && frame_full[f] && frame_pg[f] == pg) begin
        slot    = f;
        res.hit = 1'b1;
      end
    end
    if (res.hit) begin
      count_use(pg);
    end else begin
      filled = 0;
      for (int f = 0; f < n; f++) if (frame_full[f]) filled++;
      for (int f = 0; f < n; f++) if (slot == n && !frame_full[f]) slot = f;
      if (slot < n) begin
        frame_age[slot] = filled;
      end else begin
        // least count wins; on equal counts the oldest load, then lowest frame
        best     = 0;
        best_cnt = page_hits[frame_pg[0] % PAGES];
        for (int f = 1; f < n; f++) begin
          c = page_hits[frame_pg[f] % PAGES];
          if (c < best_cnt || (c == best_cnt && frame_age[f] < frame_age[best])) begin
            best     = f;
            best_cnt = c;
          end
        end
        slot         = best;
        res.ev_valid = 1'b1;
        res.ev_page  = frame_pg[slot];
        r            = frame_age[slot];
        for (int f = 0; f < n; f++) if (f != slot && frame_age[f] > r) frame_age[f]--;
        frame_age[slot] = n - 1;
      end
      frame_pg[slot]   = pg;
      frame_full[slot] = 1'b1;
      if (fault_total != FAULT_MAX) fault_total++;
      count_use(pg);
    end
    res.frame  = slot[FRAME_IDX_W-1:0];
    res.faults = fault_total;
    return res;
  endfunction

  function automatic int unsigned draw_gap();
    return quiet_burst ? 0 : $urandom_range(0, 12);
  endfunction

  // Drive one reference beat after the given gap; hold start_i and page_i
  // until the block takes it, then queue the result it owes.
  task automatic send_reference(input logic [PAGE_W-1:0] pg, input int unsigned gap,
                                input bit typed, input lfu_result_t want);
    lfu_result_t got;
    repeat (gap) begin
      start_i <= 1'b0;
      page_i  <= PAGE_W'($urandom);
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    page_i  <= pg;
    do @(posedge clk_i); while (busy_o);
    got = lfu_reference(pg);
    pending_results.push_back(typed ? want : got);
  endtask

  // Drop start_i and hold until every owed result has come back.
  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // frames_in_use may only change with nothing in flight.
  task automatic write_frames(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    frames_reg = value;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= CFG_W'($urandom);
  endtask

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
    end
  endtask

  // Results cannot be held off: compare every strobed beat against the
  // oldest owed result on the edge that ends its cycle.
  always @(posedge clk_i) begin : result_check
    lfu_result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $error("result beat with nothing owed");
      end else begin
        want = pending_results.pop_front();
        check_field("hit",           16'(want.hit),      16'(hit_o));
        check_field("frame_index",   16'(want.frame),    16'(frame_index_o));
        check_field("evicted_valid", 16'(want.ev_valid), 16'(evicted_valid_o));
        check_field("evicted_page",  16'(want.ev_page),  16'(evicted_page_o));
        check_field("fault_count",   16'(want.faults),   16'(fault_count_o));
      end
    end
  end

  // Hang detector: any accepted beat on any channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase_len;
    int unsigned n;
    logic [PAGE_W-1:0] base;
    logic [PAGE_W-1:0] pg;
    logic [CFG_W-1:0]  frames_pick;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table; the block stays busy through the count store sweep.
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (directed_plan[i].op == OP_CFG)
        write_frames(directed_plan[i].arg[CFG_W-1:0]);
      else
        send_reference(directed_plan[i].arg, draw_gap(), directed_plan[i].typed,
                       directed_plan[i].want);
    end

    // Random phases: a fresh frames_in_use each phase, pages mostly from a
    // working set a little larger than the frame count so hits, evictions
    // and count ties are common, with some fully random pages mixed in.
    sent = 0;
    while (sent < RANDOM_REFS) begin
      case ($urandom_range(0, 5))
        0:       frames_pick = CFG_W'(1);
        1:       frames_pick = CFG_W'(8);
        2:       frames_pick = CFG_W'(0);
        3:       frames_pick = CFG_W'(15);
        default: frames_pick = CFG_W'($urandom_range(0, 15));
      endcase
      write_frames(frames_pick);
      n           = active_frames();
      quiet_burst = ($urandom_range(0, 2) == 0);
      phase_len   = $urandom_range(20, 70);
      base        = PAGE_W'($urandom);
      for (int k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 9) < 2)
          pg = PAGE_W'($urandom);
        else
          pg = base + PAGE_W'($urandom_range(0, n + 3));
        send_reference(pg, draw_gap(), 1'b0, NO_WANT);
        sent++;
        if ($urandom_range(0, 29) == 0) wait_drained();
      end
    end

    // Evictions over a small page set with all eight frames active.
    quiet_burst = 1'b0;
    write_frames(CFG_W'(8));
    for (int k = 0; k < 40; k++)
      send_reference(PAGE_W'(8 + $urandom_range(0, 9)), draw_gap(), 1'b0, NO_WANT);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      mismatches++;
      $error("%0d results never arrived", pending_results.size());
    end
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
